// File: src/ptts_pkg.sv
package ptts_pkg;

  typedef enum logic [1:0] {
    FUNC_ADD      = 2'd0,
    FUNC_TICK     = 2'd1,
    FUNC_DISPATCH = 2'd2,
    FUNC_DELETE   = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_ADDED   = 2'd0,
    ST_FULL    = 2'd1,
    ST_RUN     = 2'd2,
    ST_NONE    = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] first_delay;
    logic [31:0] repeat_period;
    logic [7:0]  task_handle;
    logic [3:0]  slot_select;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] slot_number;
    logic [7:0] run_handle;
    logic       last;
  } out_item_t;

  localparam int unsigned MAX_RESULTS = 16;

  typedef enum logic [1:0] {
    EX_IDLE,
    EX_WALK,
    EX_EMIT
  } ex_state_t;

endpackage

// File: src/periodic_task_table_scheduler_top.sv
// Periodic task table scheduler.
// An accepted item passes the two-entry queue and is latched by the back end, which runs it:
// add registers its result, delete frees the selected slot, tick walks every slot. Dispatch
// walks one slot per cycle while no held result waits on a stalled output, up to the table
// end or MAX_RESULTS results. Results of one dispatch are held back one slot. One item per
// back-end pass. Reset (rst_n low, synchronous): all slots free, queue/output empty.
module periodic_task_table_scheduler_top
  import ptts_pkg::*;
#(
  parameter int unsigned TASK_SLOTS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic     q_valid, q_ready;
  in_item_t q_item;

  // Front: queue of accepted transfers
  ptts_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (in_valid),
    .wr_ready (in_ready),
    .wr_item  (in_data),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_item  (q_item)
  );

  // Back: slot table and sequencer
  ptts_exec #(.TASK_SLOTS(TASK_SLOTS)) u_exec (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (q_valid),
    .cmd_ready (q_ready),
    .cmd       (q_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_data)
  );

endmodule

// File: src/ptts_queue.sv
// Two-entry queue between the front and the back
module ptts_queue
  import ptts_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     wr_valid,
  output logic     wr_ready,
  input  in_item_t wr_item,
  output logic     rd_valid,
  input  logic     rd_ready,
  output in_item_t rd_item
);

  in_item_t   mem_r [2];
  logic       wptr_r, rptr_r;
  logic [1:0] count_r;

  assign wr_ready = (count_r != 2'd2);
  assign rd_valid = (count_r != 2'd0);
  assign rd_item  = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (wr_valid && wr_ready) begin
      mem_r[wptr_r] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= 1'b0;
      rptr_r  <= 1'b0;
      count_r <= 2'd0;
    end else begin
      if (wr_valid && wr_ready) begin
        wptr_r <= ~wptr_r;
      end
      if (rd_valid && rd_ready) begin
        rptr_r <= ~rptr_r;
      end
      count_r <= count_r + {1'b0, wr_valid && wr_ready} - {1'b0, rd_valid && rd_ready};
    end
  end

endmodule

// File: src/ptts_exec.sv
// Back end: walks the slot table one slot per cycle unless a held result is stalled
module ptts_exec
  import ptts_pkg::*;
#(
  parameter int unsigned TASK_SLOTS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cmd_valid,
  output logic      cmd_ready,
  input  in_item_t  cmd,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  localparam int unsigned SW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int unsigned CW = $clog2(TASK_SLOTS + 1);

  logic [TASK_SLOTS-1:0] used_r;
  logic [7:0]  handle_r  [TASK_SLOTS];
  logic [31:0] count_r   [TASK_SLOTS];
  logic [31:0] period_r  [TASK_SLOTS];
  logic [7:0]  pending_r [TASK_SLOTS];

  ex_state_t   state_r, state_nxt;
  in_item_t    op_r;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [4:0]  nres_r, nres_nxt;
  logic        ovalid_r, ovalid_nxt;
  out_item_t   oitem_r, oitem_nxt;
  logic        hold_r, hold_nxt;
  out_item_t   hitem_r, hitem_nxt;

  logic [SW-1:0] s;
  logic        at_end, is_last_slot, due;
  logic        free_found;
  logic [SW-1:0] free_idx;
  logic        out_free;
  logic        take;

  assign s            = idx_r[SW-1:0];
  assign is_last_slot = (idx_r == CW'(TASK_SLOTS - 1));
  assign at_end       = (idx_r == CW'(TASK_SLOTS));
  assign due          = used_r[s] && (pending_r[s] != 8'd0);
  assign out_free     = !ovalid_r || out_ready;
  assign out_valid    = ovalid_r;
  assign out_item     = oitem_r;
  assign cmd_ready    = (state_r == EX_IDLE);

  // Dispatch takes the current due slot; a held result must leave first
  assign take = (state_r == EX_WALK) && (func_t'(op_r.func) == FUNC_DISPATCH)
                && !at_end && (nres_r != 5'(MAX_RESULTS)) && due
                && (!hold_r || out_free);

  // Lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = TASK_SLOTS - 1; i >= 0; i--) begin
      if (!used_r[i]) begin
        free_found = 1'b1;
        free_idx   = SW'(i);
      end
    end
  end

  // Sequencer
  always_comb begin
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    nres_nxt   = nres_r;
    ovalid_nxt = ovalid_r && !out_ready;
    oitem_nxt  = oitem_r;
    hold_nxt   = hold_r;
    hitem_nxt  = hitem_r;
    unique case (state_r)
      EX_IDLE: begin
        if (cmd_valid) begin
          idx_nxt  = '0;
          nres_nxt = '0;
          state_nxt = EX_WALK;
        end
      end
      EX_WALK: begin
        unique case (func_t'(op_r.func))
          FUNC_ADD: begin
            if (out_free) begin
              ovalid_nxt = 1'b1;
              oitem_nxt.last = 1'b1;
              if (free_found) begin
                oitem_nxt.status      = ST_ADDED;
                oitem_nxt.slot_number = 4'(free_idx);
                oitem_nxt.run_handle  = op_r.task_handle;
              end else begin
                oitem_nxt.status      = ST_FULL;
                oitem_nxt.slot_number = '0;
                oitem_nxt.run_handle  = '0;
              end
              state_nxt = EX_IDLE;
            end
          end
          FUNC_TICK: begin
            idx_nxt = idx_r + 1'b1;
            if (is_last_slot) state_nxt = EX_IDLE;
          end
          FUNC_DELETE: begin
            state_nxt = EX_IDLE;
          end
          FUNC_DISPATCH: begin
            // a held result goes out when the next due slot is taken, or with its last flag set at the walk end
            if (at_end || nres_r == 5'(MAX_RESULTS)) begin
              state_nxt = EX_EMIT;
            end else if (due) begin
              if (take) begin
                if (hold_r) begin
                  ovalid_nxt = 1'b1;
                  oitem_nxt  = hitem_r;
                end
                hold_nxt = 1'b1;
                hitem_nxt.status      = ST_RUN;
                hitem_nxt.slot_number = 4'(s);
                hitem_nxt.run_handle  = handle_r[s];
                hitem_nxt.last        = 1'b0;
                nres_nxt = nres_r + 1'b1;
                idx_nxt  = idx_r + 1'b1;
              end
            end else begin
              idx_nxt = idx_r + 1'b1;
            end
          end
          default: state_nxt = EX_IDLE;
        endcase
      end
      EX_EMIT: begin
        // final dispatch transfer: the held result with last set, or nothing due
        if (out_free) begin
          ovalid_nxt = 1'b1;
          if (hold_r) begin
            oitem_nxt      = hitem_r;
            oitem_nxt.last = 1'b1;
          end else begin
            oitem_nxt.status      = ST_NONE;
            oitem_nxt.slot_number = '0;
            oitem_nxt.run_handle  = '0;
            oitem_nxt.last        = 1'b1;
          end
          hold_nxt  = 1'b0;
          state_nxt = EX_IDLE;
        end
      end
      default: state_nxt = EX_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= EX_IDLE;
      ovalid_r <= 1'b0;
      hold_r   <= 1'b0;
      idx_r    <= '0;
      nres_r   <= '0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
      hold_r   <= hold_nxt;
      idx_r    <= idx_nxt;
      nres_r   <= nres_nxt;
    end
  end

  always_ff @(posedge clk) begin
    oitem_r <= oitem_nxt;
    hitem_r <= hitem_nxt;
    if (state_r == EX_IDLE && cmd_valid) begin
      op_r <= cmd;
    end
  end

  // Slot table updates
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
    end else if (state_r == EX_WALK) begin
      unique case (func_t'(op_r.func))
        FUNC_ADD: begin
          if (out_free && free_found) begin
            used_r[free_idx] <= 1'b1;
          end
        end
        FUNC_DELETE: begin
          if (32'(op_r.slot_select) < TASK_SLOTS) begin
            used_r[SW'(op_r.slot_select)] <= 1'b0;
          end
        end
        FUNC_DISPATCH: begin
          if (take && period_r[s] == 32'd0) begin
            used_r[s] <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == EX_WALK) begin
      unique case (func_t'(op_r.func))
        FUNC_ADD: begin
          if (out_free && free_found) begin
            handle_r[free_idx]  <= op_r.task_handle;
            count_r[free_idx]   <= op_r.first_delay;
            period_r[free_idx]  <= op_r.repeat_period;
            pending_r[free_idx] <= 8'd0;
          end
        end
        FUNC_TICK: begin
          if (used_r[s]) begin
            if (count_r[s] != 32'd0) begin
              count_r[s] <= count_r[s] - 32'd1;
            end else begin
              count_r[s] <= period_r[s];
              if (pending_r[s] != 8'hFF) pending_r[s] <= pending_r[s] + 8'd1;
            end
          end
        end
        FUNC_DISPATCH: begin
          if (take) begin
            pending_r[s] <= pending_r[s] - 8'd1;
          end
        end
        default: ;
      endcase
    end
  end

endmodule
